// ===== rtl/masked_byte_pattern_scan_defines.svh =====
// Assertion helpers for the RTL that checks itself (the top-level scan module).
`ifndef MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH
`define MASKED_BYTE_PATTERN_SCAN_DEFINES_SVH

// Clocked check, silenced while reset is asserted.
`define MBPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define MBPS_ASSERT_NEVER(lbl, cond, msg) \
	`MBPS_ASSERT(lbl, !(cond), msg)

`endif

// ===== rtl/mbps_pkg.sv =====
package mbps_pkg;

	localparam int REQ_W        = 2;
	localparam int LEN_W        = 6;
	localparam int IN_DATA_W    = 24;
	localparam int OUT_DATA_W   = 40;
	localparam int OUT_OFFSET_W = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD = 2'd0,
		REQ_BYTE = 2'd1,
		REQ_SCAN = 2'd2
	} req_t;

	// Header of one result run, handed from the scan logic to the run buffer.
	typedef struct packed {
		logic                    found;
		logic [OUT_OFFSET_W-1:0] offset;
	} run_load_t;

endpackage

// ===== rtl/masked_byte_pattern_scan.sv =====
// Channel  | Direction | Carries
// s_*      | in        | tuser req_type, tdata entry fields and mem_byte, tlast last_byte
// m_*      | out       | tuser match_found, tdata match_offset and captured_byte,
//          |           | tlast last_of_run
// cfg_*    | in        | pattern_length write
//
// An item is held in an input register and resolved there by the window
// compare; a match or a scan end loads the run buffer, which presents one
// result per cycle while m_tready is high, from the following cycle on. Items
// are taken one per cycle, except that a memory byte of an unfinished scan
// waits while an earlier run is still being drained. Reset clears the scan
// state and sets pattern_length to 1; pattern entries hold nothing until loaded.
module masked_byte_pattern_scan #(
	parameter int PATTERN_MAX = 32,
	parameter int OFFSET_BITS = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// entry_index[4:0], entry_value[12:5], entry_care[13], mem_byte[21:14], zero[23:22]
	input  logic [mbps_pkg::IN_DATA_W-1:0]      s_tdata,
	// req_type
	input  logic [mbps_pkg::REQ_W-1:0]          s_tuser,
	// last_byte
	input  logic                                s_tlast,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// match_offset[31:0], captured_byte[39:32]
	output logic [mbps_pkg::OUT_DATA_W-1:0]     m_tdata,
	// match_found
	output logic                                m_tuser,
	// last_of_run
	output logic                                m_tlast,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [mbps_pkg::LEN_W-1:0]          cfg_data
);
	import mbps_pkg::*;

	`include "masked_byte_pattern_scan_defines.svh"

	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int OW = (OFFSET_BITS > OUT_OFFSET_W) ? OFFSET_BITS : OUT_OFFSET_W;

	// Input stage.
	logic                        valid_s1;
	req_t                        req_s1;
	logic [4:0]                  index_s1;
	logic [7:0]                  value_s1;
	logic                        care_s1;
	logic [7:0]                  byte_s1;
	logic                        last_s1;

	// Scan state.
	logic [LEN_W-1:0]            length_q;
	logic [PATTERN_MAX-1:0][7:0] pattern_q;
	logic [PATTERN_MAX-1:0]      care_q;
	logic [PATTERN_MAX-1:0][7:0] window_q;
	logic [LW-1:0]               fill_q;
	logic [OFFSET_BITS-1:0]      seen_q;
	logic                        finished_q;

	logic [6:0]                  length_ext;
	logic [LW-1:0]               eff_len;
	logic [LW-1:0]               fill_next;
	logic [OFFSET_BITS-1:0]      seen_next;
	logic [OFFSET_BITS-1:0]      start_offset;
	logic [OW-1:0]               start_offset_ext;
	logic [PATTERN_MAX-1:0][7:0] window_next;
	logic [PATTERN_MAX-1:0][7:0] aligned;
	logic                        hit;
	logic                        may_emit;
	logic                        run_free;
	logic                        advance;
	logic                        exec;
	logic                        scan_byte;
	logic                        run_load;
	run_load_t                   run_hdr;
	logic [LW-1:0]               run_len;
	logic [PATTERN_MAX-1:0][7:0] run_bytes;

	assign cfg_ready = 1'b1;

	// A length of zero acts as one; beyond the store depth it is clamped.
	assign length_ext = {1'b0, length_q};
	always_comb begin
		if (length_ext == 7'd0) begin
			eff_len = LW'(1);
		end else if (length_ext > 7'(PATTERN_MAX)) begin
			eff_len = LW'(PATTERN_MAX);
		end else begin
			eff_len = LW'(length_ext);
		end
	end

	assign fill_next = (fill_q == LW'(PATTERN_MAX)) ? fill_q : fill_q + LW'(1);
	assign seen_next = seen_q + OFFSET_BITS'(1);
	assign start_offset     = seen_next - OFFSET_BITS'(eff_len);
	assign start_offset_ext = OW'(start_offset);

	always_comb begin
		window_next[0] = byte_s1;
		for (int i = 1; i < PATTERN_MAX; i++) begin
			window_next[i] = window_q[i-1];
		end
	end

	mbps_match #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_match (
		.eff_len   (eff_len),
		.fill_next (fill_next),
		.window    (window_next),
		.pattern   (pattern_q),
		.care      (care_q),
		.hit       (hit),
		.aligned   (aligned)
	);

	// Only a memory byte of an unfinished scan can start a run, so only such an
	// item has to wait for the run buffer.
	assign may_emit  = (req_s1 == REQ_BYTE) && !finished_q;
	assign advance   = !may_emit || run_free;
	assign exec      = valid_s1 && advance;
	assign s_tready  = !valid_s1 || advance;
	assign scan_byte = exec && may_emit;
	assign run_load  = scan_byte && (hit || last_s1);

	always_comb begin
		if (hit) begin
			run_hdr.found  = 1'b1;
			run_hdr.offset = start_offset_ext[OUT_OFFSET_W-1:0];
			run_len        = eff_len;
			run_bytes      = aligned;
		end else begin
			run_hdr.found  = 1'b0;
			run_hdr.offset = '0;
			run_len        = LW'(1);
			run_bytes      = '0;
		end
	end

	mbps_run #(
		.PATTERN_MAX (PATTERN_MAX)
	) u_run (
		.clk        (clk),
		.arst_n     (arst_n),
		.load       (run_load),
		.load_hdr   (run_hdr),
		.load_len   (run_len),
		.load_bytes (run_bytes),
		.run_free   (run_free),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1   <= req_t'(s_tuser);
			index_s1 <= s_tdata[4:0];
			value_s1 <= s_tdata[12:5];
			care_s1  <= s_tdata[13];
			byte_s1  <= s_tdata[21:14];
			last_s1  <= s_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			length_q <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q     <= '0;
			seen_q     <= '0;
			finished_q <= 1'b0;
		end else if (exec) begin
			case (req_s1)
				REQ_SCAN: begin
					fill_q     <= '0;
					seen_q     <= '0;
					finished_q <= 1'b0;
				end
				REQ_BYTE: begin
					if (!finished_q) begin
						fill_q     <= fill_next;
						seen_q     <= seen_next;
						finished_q <= hit || last_s1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// The window needs no clearing: the fill count keeps stale bytes out of any
	// compare or capture.
	always_ff @(posedge clk) begin
		if (scan_byte) begin
			window_q <= window_next;
		end
	end

	// Pattern entries are written by a load item, or the first eff_len of them at
	// once with the captured window when a match is found.
	always_ff @(posedge clk) begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			if (exec && (req_s1 == REQ_LOAD) && (32'(index_s1) == i)) begin
				pattern_q[i] <= value_s1;
				care_q[i]    <= care_s1;
			end else if (scan_byte && hit && (LW'(i) < eff_len)) begin
				pattern_q[i] <= aligned[i];
				care_q[i]    <= 1'b1;
			end
		end
	end

	`MBPS_ASSERT(a_run_load_free, run_load |-> run_free, "run loaded while results still pending")
	`MBPS_ASSERT(a_run_shows, run_load |=> m_tvalid, "loaded run not presented")
	`MBPS_ASSERT_NEVER(a_no_emit_after_end, run_load && finished_q, "result after scan end")
	`MBPS_ASSERT(a_nomatch_single, (m_tvalid && !m_tuser) |-> m_tlast, "no-match run longer than one")

endmodule

// ===== rtl/mbps_match.sv =====
module mbps_match #(
	parameter int PATTERN_MAX = 32
) (
	input  logic [$clog2(PATTERN_MAX+1)-1:0] eff_len,
	input  logic [$clog2(PATTERN_MAX+1)-1:0] fill_next,
	input  logic [PATTERN_MAX-1:0][7:0]      window,
	input  logic [PATTERN_MAX-1:0][7:0]      pattern,
	input  logic [PATTERN_MAX-1:0]           care,
	output logic                             hit,
	output logic [PATTERN_MAX-1:0][7:0]      aligned
);
	import mbps_pkg::*;

	localparam int LW = $clog2(PATTERN_MAX + 1);
	localparam int SW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;

	logic [PATTERN_MAX-1:0][7:0] oldest_first;
	logic [SW-1:0]               shift_bytes;
	logic [PATTERN_MAX-1:0]      lane_ok;

	// The window holds the newest byte at lane 0. Reversing it and shifting out
	// the bytes older than the pattern puts the window start at lane 0.
	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			oldest_first[i] = window[PATTERN_MAX-1-i];
		end
	end

	assign shift_bytes = SW'(LW'(PATTERN_MAX) - eff_len);
	assign aligned     = oldest_first >> {shift_bytes, 3'b000};

	always_comb begin
		for (int i = 0; i < PATTERN_MAX; i++) begin
			lane_ok[i] = (LW'(i) >= eff_len) || !care[i] || (pattern[i] == aligned[i]);
		end
	end

	assign hit = (fill_next >= eff_len) && (&lane_ok);

endmodule

// ===== rtl/mbps_run.sv =====
module mbps_run #(
	parameter int PATTERN_MAX = 32
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 load,
	input  mbps_pkg::run_load_t                  load_hdr,
	input  logic [$clog2(PATTERN_MAX+1)-1:0]     load_len,
	input  logic [PATTERN_MAX-1:0][7:0]          load_bytes,
	output logic                                 run_free,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// match_offset[31:0], captured_byte[39:32]
	output logic [mbps_pkg::OUT_DATA_W-1:0]      m_tdata,
	// match_found
	output logic                                 m_tuser,
	// last_of_run
	output logic                                 m_tlast
);
	import mbps_pkg::*;

	localparam int LW = $clog2(PATTERN_MAX + 1);

	logic [LW-1:0]               left_q;
	logic [PATTERN_MAX-1:0][7:0] bytes_q;
	run_load_t                   hdr_q;
	logic                        take;

	assign m_tvalid = (left_q != '0);
	assign take     = m_tvalid && m_tready;
	assign m_tlast  = (left_q == LW'(1));
	assign run_free = !m_tvalid || (take && m_tlast);
	assign m_tuser  = hdr_q.found;
	assign m_tdata  = {bytes_q[0], hdr_q.offset};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (load) begin
			left_q <= load_len;
		end else if (take) begin
			left_q <= left_q - LW'(1);
		end
	end

	// Each taken item moves the next captured byte to the head.
	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q <= load_bytes;
			hdr_q   <= load_hdr;
		end else if (take) begin
			bytes_q <= bytes_q >> 8;
		end
	end

endmodule
